// ===== sv/tls_client_hello_sni_extractor_assert.svh =====
// Assertion macros used by the output queue module.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_ASSERT_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TCH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the next cycle.
`define TCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tchs_pkg.sv =====
package tchs_pkg;

  localparam int unsigned CaptureLenDefault  = 512;
  localparam int unsigned MaxLabelDefault    = 63;
  localparam int unsigned MaxNameWireDefault = 255;

  // Configuration register indexes.
  localparam logic CfgHdrMode = 1'b0;
  localparam logic CfgMaxName = 1'b1;

  // Verdict codes.
  localparam logic [1:0] StFound      = 2'd0;
  localparam logic [1:0] StMalformed  = 2'd1;
  localparam logic [1:0] StIncomplete = 2'd2;

  // Parser phases.
  typedef enum logic [14:0] {
    PhHdr      = 15'b000000000000001,
    PhHs       = 15'b000000000000010,
    PhFixed    = 15'b000000000000100,
    PhSessLen  = 15'b000000000001000,
    PhSessSkip = 15'b000000000010000,
    PhCsLen    = 15'b000000000100000,
    PhCsSkip   = 15'b000000001000000,
    PhCompLen  = 15'b000000010000000,
    PhCompSkip = 15'b000000100000000,
    PhExtTotal = 15'b000001000000000,
    PhExtHdr   = 15'b000010000000000,
    PhExtSkip  = 15'b000100000000000,
    PhSniHdr   = 15'b001000000000000,
    PhName     = 15'b010000000000000,
    PhDone     = 15'b100000000000000
  } phase_e;

  // One result transaction as it travels to the output queue.
  typedef struct packed {
    logic       is_verdict;
    logic [7:0] name_char;
    logic [1:0] status;
  } result_t;

  // Allowed hostname character other than the dot.
  function automatic logic name_char_ok(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2d;
  endfunction

endpackage

// ===== sv/tchs_parser.sv =====
module tchs_parser import tchs_pkg::*; #(
  parameter int unsigned CaptureLen  = CaptureLenDefault,
  parameter int unsigned MaxLabel    = MaxLabelDefault,
  parameter int unsigned MaxNameWire = MaxNameWireDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       hdr_mode_i,
  input  logic [8:0] max_name_i,
  output logic       emit_char_o,
  output logic       emit_verdict_o,
  output result_t    char_o,
  output result_t    verdict_o
);

  localparam int unsigned PosW = $clog2(CaptureLen + 1);

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          ph_q, ph_d;
  logic [23:0]     hello_q, hello_d;
  logic [15:0]     fld_q, fld_d;
  logic [15:0]     extr_q, extr_d;
  logic [15:0]     extl_q, extl_d;
  logic [15:0]     nll_q, nll_d;
  logic [15:0]     nl_q, nl_d;
  logic [8:0]      lbl_q, lbl_d;
  logic [7:0]      prev_q, prev_d;
  logic            early_q, early_d;
  logic            found_q, found_d;
  logic [2:0]      sub_q, sub_d;
  logic            sni_q, sni_d;
  logic            hdr_q, hdr_d;

  // Combinational byte walk; one byte per cycle while in_valid_i is high.
  always_comb begin
    logic       take;
    logic       emit;
    logic       fault;
    logic       first;
    logic [7:0] b;
    logic [15:0] ext_after;
    logic [PosW-1:0] need;
    logic [1:0] st;
    pos_d = pos_q; ph_d = ph_q; hello_d = hello_q; fld_d = fld_q;
    extr_d = extr_q; extl_d = extl_q; nll_d = nll_q; nl_d = nl_q;
    lbl_d = lbl_q; prev_d = prev_q; early_d = early_q; found_d = found_q;
    sub_d = sub_q; sni_d = sni_q; hdr_d = hdr_q;
    emit = 1'b0; fault = 1'b0;
    b = data_byte_i;
    first = 1'b0;
    ext_after = extr_q - 16'd4;
    take = in_valid_i && (pos_q < PosW'(CaptureLen));

    if (take) begin
      if (pos_q == '0) begin
        hdr_d = hdr_mode_i;
        ph_d = hdr_mode_i ? PhHdr : PhHs;
        sub_d = '0;
      end
      pos_d = pos_q + 1'b1;
      if (ph_d == PhHdr) begin
        if ((pos_q == PosW'(0) && b != 8'h16) || (pos_q == PosW'(1) && b != 8'h03) ||
            (pos_q == PosW'(2) && (b < 8'd1 || b > 8'd3))) begin
          early_d = 1'b1;
          ph_d = PhDone;
        end else if (pos_q >= PosW'(4)) begin
          ph_d = PhHs;
          sub_d = '0;
        end
      end else if (ph_d == PhHs) begin
        if (sub_d == 3'd0 && b != 8'h01) begin
          early_d = 1'b1;
          ph_d = PhDone;
        end else begin
          if (sub_d != 3'd0) hello_d = {hello_q[15:0], b};
          sub_d = sub_d + 3'd1;
          if (sub_d == 3'd4) begin
            ph_d = PhFixed;
            fld_d = 16'd34;
            sub_d = '0;
          end
        end
      end else if (!early_q && hello_q != '0) begin
        hello_d = hello_q - 24'd1;
        if (ph_q != PhDone) begin
          case (ph_q)
            PhFixed: begin
              fld_d = fld_q - 16'd1;
              if (fld_d == '0) ph_d = PhSessLen;
            end
            PhSessLen: begin
              fld_d = {8'd0, b}; sub_d = '0;
              ph_d = (b == 8'd0) ? PhCsLen : PhSessSkip;
            end
            PhCompLen: begin
              fld_d = {8'd0, b}; sub_d = '0;
              ph_d = (b == 8'd0) ? PhExtTotal : PhCompSkip;
            end
            PhSessSkip, PhCsSkip, PhCompSkip: begin
              fld_d = fld_q - 16'd1;
              if (fld_d == '0) begin
                sub_d = '0;
                ph_d = (ph_q == PhSessSkip) ? PhCsLen :
                       (ph_q == PhCsSkip) ? PhCompLen : PhExtTotal;
              end
            end
            PhCsLen: begin
              fld_d = {fld_q[7:0], b};
              if (sub_q == 3'd0) sub_d = 3'd1;
              else ph_d = (fld_d == '0) ? PhCompLen : PhCsSkip;
            end
            PhExtTotal: begin
              extr_d = {extr_q[7:0], b};
              if (sub_q == 3'd0) sub_d = 3'd1;
              else if ({8'd0, extr_d} > hello_d) fault = 1'b1;
              else if (extr_d < 16'd4) fault = 1'b1;
              else begin ph_d = PhExtHdr; sub_d = '0; end
            end
            PhExtHdr: begin
              if (sub_q == 3'd0) sni_d = (b == 8'd0);
              else if (sub_q == 3'd1) sni_d = sni_q && (b == 8'd0);
              else extl_d = {extl_q[7:0], b};
              sub_d = sub_q + 3'd1;
              if (sub_d == 3'd4) begin
                extr_d = ext_after;
                if (extl_d > ext_after) fault = 1'b1;
                else if (sni_q) begin
                  if (extl_d < 16'd5) fault = 1'b1;
                  else begin ph_d = PhSniHdr; sub_d = '0; end
                end else begin
                  extr_d = ext_after - extl_d;
                  if (extl_d == '0) begin
                    if (extr_d < 16'd4) fault = 1'b1;
                    else begin ph_d = PhExtHdr; sub_d = '0; end
                  end else begin
                    fld_d = extl_d;
                    ph_d = PhExtSkip;
                  end
                end
              end
            end
            PhExtSkip: begin
              fld_d = fld_q - 16'd1;
              if (fld_d == '0) begin
                if (extr_q < 16'd4) fault = 1'b1;
                else begin ph_d = PhExtHdr; sub_d = '0; end
              end
            end
            PhSniHdr: begin
              sub_d = sub_q + 3'd1;
              if (sub_q < 3'd2) begin
                nll_d = {nll_q[7:0], b};
                if (sub_q == 3'd1 && {nll_d} + 16'd2 != extl_q) fault = 1'b1;
              end else if (sub_q == 3'd2) begin
                if (b != 8'd0) fault = 1'b1;
              end else begin
                nl_d = {nl_q[7:0], b};
                if (sub_q == 3'd4) begin
                  if ({1'b0, nl_d} + 17'd3 != {1'b0, nll_q} ||
                      nl_d >= {7'd0, max_name_i} || nl_d == '0 ||
                      nl_d > 16'(MaxNameWire)) fault = 1'b1;
                  else begin
                    fld_d = nl_d; lbl_d = '0; prev_d = '0; ph_d = PhName;
                  end
                end
              end
            end
            PhName: begin
              first = (fld_q == nl_q);
              if (b == 8'h2e) begin
                if (first || lbl_q == '0 || prev_q == 8'h2d) fault = 1'b1;
                else lbl_d = '0;
              end else if (name_char_ok(b)) begin
                lbl_d = lbl_q + 9'd1;
                if (b == 8'h2d && (first || prev_q == 8'h2e)) fault = 1'b1;
                else if (lbl_d > 9'(MaxLabel)) fault = 1'b1;
              end else fault = 1'b1;
              if (!fault) begin
                emit = 1'b1;
                prev_d = b;
                fld_d = fld_q - 16'd1;
                if (fld_d == '0) begin
                  if (b == 8'h2d || lbl_d == '0) fault = 1'b1;
                  else begin found_d = 1'b1; ph_d = PhDone; end
                end
              end
            end
            default: ;
          endcase
          if (fault) ph_d = PhDone;
          if (hello_d == '0 && ph_d != PhDone) ph_d = PhDone;
        end
      end
    end

    // Verdict from the updated state.
    need = hdr_d ? PosW'(43) : PosW'(38);
    if (max_name_i <= 9'd1) st = StMalformed;
    else if (pos_d < need) st = StMalformed;
    else if (early_d) st = StMalformed;
    else if (hello_d != '0) st = StIncomplete;
    else st = found_d ? StFound : StMalformed;

    emit_char_o = emit;
    emit_verdict_o = in_valid_i && last_byte_i;
    char_o = '{is_verdict: 1'b0, name_char: b, status: StFound};
    verdict_o = '{is_verdict: 1'b1, name_char: 8'd0, status: st};

    // End of message returns all parser state to reset.
    if (in_valid_i && last_byte_i) begin
      pos_d = '0; ph_d = PhHdr; hello_d = '0; fld_d = '0; extr_d = '0;
      extl_d = '0; nll_d = '0; nl_d = '0; lbl_d = '0; prev_d = '0;
      early_d = 1'b0; found_d = 1'b0; sub_d = '0; sni_d = 1'b0; hdr_d = 1'b1;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; ph_q <= PhHdr; hello_q <= '0; fld_q <= '0; extr_q <= '0;
      extl_q <= '0; nll_q <= '0; nl_q <= '0; lbl_q <= '0; prev_q <= '0;
      early_q <= 1'b0; found_q <= 1'b0; sub_q <= '0; sni_q <= 1'b0; hdr_q <= 1'b1;
    end else begin
      pos_q <= pos_d; ph_q <= ph_d; hello_q <= hello_d; fld_q <= fld_d;
      extr_q <= extr_d; extl_q <= extl_d; nll_q <= nll_d; nl_q <= nl_d;
      lbl_q <= lbl_d; prev_q <= prev_d; early_q <= early_d; found_q <= found_d;
      sub_q <= sub_d; sni_q <= sni_d; hdr_q <= hdr_d;
    end
  end

endmodule

// ===== sv/tchs_out_fifo.sv =====
module tchs_out_fifo import tchs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_a_i,
  input  result_t data_a_i,
  input  logic    wr_b_i,
  input  result_t data_b_i,
  input  logic    pop_i,
  output logic    empty_o,
  output logic    room_o,
  output result_t head_o
);

  `include "tls_client_hello_sni_extractor_assert.svh"

  localparam int unsigned Depth = 4;

  result_t    mem_q [Depth];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       do_pop;
  logic [1:0] nwr;

  assign empty_o = (cnt_q == 3'd0);
  assign room_o  = (cnt_q <= 3'd2);
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;
  assign nwr     = {1'b0, wr_a_i} + {1'b0, wr_b_i};

  // Up to two results written in one cycle, in order.
  always_ff @(posedge clk_i) begin
    if (wr_a_i) mem_q[wr_q] <= data_a_i;
    if (wr_b_i) mem_q[wr_a_i ? wr_q + 2'd1 : wr_q] <= data_b_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + nwr;
      rd_q  <= rd_q + {1'b0, do_pop};
      cnt_q <= cnt_q + {1'b0, nwr} - {2'b0, do_pop};
    end
  end

  `TCH_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, cnt_q > 3'd2, nwr == 2'd0 || do_pop,
    "queue overflow")
  `TCH_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= 3'd4, "count range")
  `TCH_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, do_pop && nwr == 2'd0,
    cnt_q == $past(cnt_q) - 3'd1, "pop lost")

endmodule

// ===== sv/tls_client_hello_sni_extractor.sv =====
// TLS ClientHello SNI extractor.
// Input channel: data_byte_i/last_byte_i are taken when push is high and
// full is low; one captured byte per transaction, last_byte_i marks the end.
// Result channel: while empty is low the oldest result is on is_verdict_o,
// name_char_o and status_o; pop high takes it.
// Each valid hostname byte gives one character result; the last byte adds a
// verdict result (0 found, 1 malformed, 2 incomplete).
// A result is visible the cycle after its byte is taken. Throughput: one byte
// per cycle while full is low. A four-entry result queue decouples parser and
// receiver. When the receiver stalls, full rises once fewer than two entries
// are free. Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 header mode, 1 max name length); the user writes only while the block
// is idle, and the block itself does not enforce it.
// Reset: registers return to header mode 1 and max length 256; queue empties.
module tls_client_hello_sni_extractor import tchs_pkg::*; #(
  parameter int unsigned CaptureLen  = CaptureLenDefault,
  parameter int unsigned MaxLabel    = MaxLabelDefault,
  parameter int unsigned MaxNameWire = MaxNameWireDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       is_verdict_o,
  output logic [7:0] name_char_o,
  output logic [1:0] status_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [8:0] cfg_wdata_i
);

  logic       hdr_mode_q;
  logic [8:0] max_name_q;
  logic       in_valid, emit_char, emit_verdict, room;
  result_t    char_res, verdict_res, head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mode_q <= 1'b1;
      max_name_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHdrMode: hdr_mode_q <= cfg_wdata_i[0];
        CfgMaxName: max_name_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign full     = !room;
  assign in_valid = push && room;

  tchs_parser #(
    .CaptureLen (CaptureLen),
    .MaxLabel   (MaxLabel),
    .MaxNameWire(MaxNameWire)
  ) u_parser (
    .clk_i, .rst_ni,
    .in_valid_i    (in_valid),
    .data_byte_i,
    .last_byte_i,
    .hdr_mode_i    (hdr_mode_q),
    .max_name_i    (max_name_q),
    .emit_char_o   (emit_char),
    .emit_verdict_o(emit_verdict),
    .char_o        (char_res),
    .verdict_o     (verdict_res)
  );

  tchs_out_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_a_i  (emit_char),
    .data_a_i(char_res),
    .wr_b_i  (emit_verdict),
    .data_b_i(verdict_res),
    .pop_i   (pop),
    .empty_o (empty),
    .room_o  (room),
    .head_o  (head)
  );

  assign is_verdict_o = head.is_verdict;
  assign name_char_o  = head.name_char;
  assign status_o     = head.status;

endmodule
